>>> rtl/core/mau_pkg.sv
package mau_pkg;

	localparam int unsigned DIM_DEF = 4;
	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned ELEM_W = 32;

	typedef enum logic [3:0] {
		OP_WRITE_ACC = 4'd0,
		OP_WRITE_OPD = 4'd1,
		OP_IDENTITY  = 4'd2,
		OP_ADD       = 4'd3,
		OP_SUB       = 4'd4,
		OP_MATMUL    = 4'd5,
		OP_SCALE     = 4'd6,
		OP_DIVIDE    = 4'd7,
		OP_READ      = 4'd8
	} opcode_t;

	typedef struct packed {
		logic [3:0]         opcode;
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] element;
		logic               saturated;
		logic               divide_by_zero;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_WAIT,
		ST_EXEC,
		ST_MM_RD,
		ST_MM_WAIT,
		ST_MM_ACC,
		ST_MM_WB,
		ST_DIV,
		ST_COPY_RD,
		ST_COPY_WAIT,
		ST_COPY_WR,
		ST_FIN_RD,
		ST_FIN_WAIT,
		ST_OUT
	} state_t;

	function automatic logic signed [31:0] clamp32(input logic signed [65:0] v,
			output logic sat);
		logic signed [31:0] r;
		sat = 1'b0;
		r = v[31:0];
		if (v > 66'sh7FFF_FFFF) begin
			sat = 1'b1;
			r = 32'sh7FFF_FFFF;
		end else if (v < -66'sh8000_0000) begin
			sat = 1'b1;
			r = 32'sh8000_0000;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/matrix4x4_arithmetic_unit_core.sv
// Matrix arithmetic unit: a DIM x DIM accumulator A and operand B in signed
// fixed point, both held in single-port-write synchronous RAMs.
// Input channel in_valid/in_stall/in_data carries one command transaction:
// opcode, row, col, value. Output channel out_valid/out_stall/out_data returns
// the accumulator element A[row][col] after the command plus flags.
// One transaction is processed at a time; in_stall is high while busy.
// Writes and reads end by reading A back for the output. Identity writes each
// element in turn; add, sub and scale read and write back each of the 16 elements;
// divide runs the 48-step bit-serial divider for each element, or with a zero
// divisor only sets the flag and leaves A as it is; matmul runs DIM multiply-
// accumulates per element through the shared product register into a scratch
// RAM, then copies it back into A. The multiplies, the divider and the single
// read port set the rate.
// Reset clears both matrices by a sweep over all DIM*DIM elements, during which
// in_stall is high. When the receiver stalls, the result holds in the output
// register and no new transaction is taken until it is delivered.
module matrix4x4_arithmetic_unit_core #(
	parameter int unsigned DIM = mau_pkg::DIM_DEF,
	parameter int unsigned FRAC_BITS = mau_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mau_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mau_pkg::out_item_t  out_data
);

	localparam int unsigned N = DIM * DIM;
	localparam int unsigned AW = (N > 1) ? $clog2(N) : 1;
	localparam int unsigned KW = (DIM > 1) ? $clog2(DIM) : 1;

	mau_pkg::state_t state_q, state_d;
	logic          clr_q;
	logic [AW:0]   clr_cnt_q;
	mau_pkg::in_item_t cmd_q;
	logic [AW-1:0] idx_q;
	logic [KW-1:0] k_q;
	logic          sat_q;
	logic          dz_q;
	logic signed [65:0] acc_q;
	logic signed [31:0] a_s1;
	logic signed [63:0] prod_s2;

	logic          a_we, b_we, t_we;
	logic [AW-1:0] a_wa, b_wa, t_wa, a_ra, b_ra, t_ra;
	logic [31:0]   a_wd, b_wd, t_wd, a_rd, b_rd, t_rd;

	logic          addr_ok;
	logic [AW-1:0] cmd_idx;
	logic [KW-1:0] ri, ci;
	logic          div_start, div_done;
	logic signed [63:0] div_q;
	logic signed [65:0] wide;
	logic signed [31:0] res;
	logic          res_sat;
	logic signed [65:0] mm_sum;
	logic signed [65:0] mm_sh;

	mau_ram #(.WIDTH(32), .DEPTH(N)) u_a (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
	mau_ram #(.WIDTH(32), .DEPTH(N)) u_b (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
	mau_ram #(.WIDTH(32), .DEPTH(N)) u_t (
		.clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));

	mau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num($signed(a_rd)),
		.den(cmd_q.value), .done(div_done), .quot(div_q));

	assign addr_ok = (32'(cmd_q.row) < DIM) && (32'(cmd_q.col) < DIM);
	assign cmd_idx = AW'(32'(cmd_q.row) * DIM + 32'(cmd_q.col));
	assign mm_sum = acc_q + 66'(prod_s2);
	assign mm_sh = mm_sum >>> FRAC_BITS;

	always_comb begin
		ri = '0;
		ci = '0;
		for (int i = 0; i < N; i++) begin
			if (idx_q == AW'(i)) begin
				ri = KW'(i / DIM);
				ci = KW'(i % DIM);
			end
		end
	end

	always_comb begin
		wide = '0;
		case (cmd_q.opcode)
			mau_pkg::OP_ADD: wide = 66'($signed(a_rd)) + 66'($signed(b_rd));
			mau_pkg::OP_SUB: wide = 66'($signed(a_rd)) - 66'($signed(b_rd));
			mau_pkg::OP_SCALE: wide = 66'(prod_s2 >>> FRAC_BITS);
			mau_pkg::OP_DIVIDE: wide = 66'(div_q);
			mau_pkg::OP_MATMUL: wide = mm_sh;
			default: wide = '0;
		endcase
		res = mau_pkg::clamp32(wide, res_sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mau_pkg::ST_IDLE;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (AW+1)'(N - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (state_q == mau_pkg::ST_OUT) begin
				out_valid <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		a_we = 1'b0; b_we = 1'b0; t_we = 1'b0;
		a_wa = idx_q; b_wa = cmd_idx; t_wa = idx_q;
		a_wd = 32'(res); b_wd = cmd_q.value; t_wd = 32'(res);
		a_ra = idx_q; b_ra = idx_q; t_ra = idx_q;
		div_start = 1'b0;
		in_stall = 1'b1;
		if (clr_q) begin
			a_we = 1'b1; b_we = 1'b1;
			a_wa = clr_cnt_q[AW-1:0]; b_wa = clr_cnt_q[AW-1:0];
			a_wd = '0; b_wd = '0;
		end else begin
			case (state_q)
				mau_pkg::ST_IDLE: begin
					in_stall = out_valid;
					if (in_valid && !out_valid) begin
						state_d = mau_pkg::ST_RD;
					end
				end
				mau_pkg::ST_RD: begin
					case (cmd_q.opcode)
						mau_pkg::OP_WRITE_ACC: begin
							a_we = addr_ok; a_wa = cmd_idx; a_wd = cmd_q.value;
							state_d = mau_pkg::ST_FIN_RD;
						end
						mau_pkg::OP_WRITE_OPD: begin
							b_we = addr_ok;
							state_d = mau_pkg::ST_FIN_RD;
						end
						mau_pkg::OP_IDENTITY: begin
							a_we = 1'b1;
							a_wd = (ri == ci) ? (32'd1 << FRAC_BITS) : 32'd0;
							state_d = (32'(idx_q) == N - 1) ? mau_pkg::ST_FIN_RD
								: mau_pkg::ST_RD;
						end
						mau_pkg::OP_ADD, mau_pkg::OP_SUB, mau_pkg::OP_SCALE:
							state_d = mau_pkg::ST_WAIT;
						mau_pkg::OP_DIVIDE:
							state_d = (cmd_q.value == 0) ? mau_pkg::ST_FIN_RD
								: mau_pkg::ST_WAIT;
						mau_pkg::OP_MATMUL: state_d = mau_pkg::ST_MM_RD;
						default: state_d = mau_pkg::ST_FIN_RD;
					endcase
				end
				mau_pkg::ST_WAIT: begin
					if (cmd_q.opcode == mau_pkg::OP_DIVIDE) begin
						div_start = 1'b1;
						state_d = mau_pkg::ST_DIV;
					end else begin
						state_d = mau_pkg::ST_EXEC;
					end
				end
				mau_pkg::ST_DIV: begin
					if (div_done) begin
						state_d = mau_pkg::ST_EXEC;
					end
				end
				mau_pkg::ST_EXEC: begin
					a_we = 1'b1;
					state_d = (32'(idx_q) == N - 1) ? mau_pkg::ST_FIN_RD : mau_pkg::ST_RD;
				end
				mau_pkg::ST_MM_RD: begin
					a_ra = AW'(32'(ri) * DIM + 32'(k_q));
					b_ra = AW'(32'(k_q) * DIM + 32'(ci));
					state_d = mau_pkg::ST_MM_WAIT;
				end
				mau_pkg::ST_MM_WAIT: begin
					a_ra = AW'(32'(ri) * DIM + 32'(k_q));
					b_ra = AW'(32'(k_q) * DIM + 32'(ci));
					state_d = mau_pkg::ST_MM_ACC;
				end
				mau_pkg::ST_MM_ACC: begin
					state_d = (32'(k_q) == DIM - 1) ? mau_pkg::ST_MM_WB
						: mau_pkg::ST_MM_RD;
				end
				mau_pkg::ST_MM_WB: begin
					t_we = 1'b1;
					state_d = (32'(idx_q) == N - 1) ? mau_pkg::ST_COPY_RD
						: mau_pkg::ST_MM_RD;
				end
				mau_pkg::ST_COPY_RD: state_d = mau_pkg::ST_COPY_WAIT;
				mau_pkg::ST_COPY_WAIT: state_d = mau_pkg::ST_COPY_WR;
				mau_pkg::ST_COPY_WR: begin
					a_we = 1'b1; a_wd = t_rd;
					state_d = (32'(idx_q) == N - 1) ? mau_pkg::ST_FIN_RD
						: mau_pkg::ST_COPY_RD;
				end
				mau_pkg::ST_FIN_RD: begin
					a_ra = cmd_idx;
					state_d = mau_pkg::ST_FIN_WAIT;
				end
				mau_pkg::ST_FIN_WAIT: begin
					a_ra = cmd_idx;
					state_d = mau_pkg::ST_OUT;
				end
				mau_pkg::ST_OUT: state_d = mau_pkg::ST_IDLE;
				default: state_d = mau_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mau_pkg::ST_IDLE: begin
				cmd_q <= in_data;
				idx_q <= '0;
				k_q <= '0;
				sat_q <= 1'b0;
				dz_q <= 1'b0;
				acc_q <= '0;
			end
			mau_pkg::ST_RD: begin
				if (cmd_q.opcode == mau_pkg::OP_IDENTITY) begin
					idx_q <= idx_q + 1'b1;
				end
				if (cmd_q.opcode == mau_pkg::OP_DIVIDE && cmd_q.value == 0) begin
					dz_q <= 1'b1;
				end
			end
			mau_pkg::ST_WAIT: prod_s2 <= 64'($signed(a_rd)) * 64'(cmd_q.value);
			mau_pkg::ST_EXEC: begin
				sat_q <= sat_q | res_sat;
				idx_q <= idx_q + 1'b1;
			end
			mau_pkg::ST_MM_WAIT: a_s1 <= $signed(a_rd);
			mau_pkg::ST_MM_ACC: begin
				acc_q <= mm_sum;
				prod_s2 <= 64'(a_s1) * 64'($signed(b_rd));
				k_q <= k_q + 1'b1;
			end
			mau_pkg::ST_MM_RD: begin
				if (32'(k_q) == 0) begin
					prod_s2 <= '0;
				end
			end
			mau_pkg::ST_MM_WB: begin
				sat_q <= sat_q | res_sat;
				acc_q <= '0;
				k_q <= '0;
				idx_q <= (32'(idx_q) == N - 1) ? '0 : idx_q + 1'b1;
			end
			mau_pkg::ST_COPY_WR: idx_q <= idx_q + 1'b1;
			mau_pkg::ST_OUT: begin
				out_data.element <= addr_ok ? $signed(a_rd) : 32'sd0;
				out_data.saturated <= sat_q;
				out_data.divide_by_zero <= dz_q;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/core/mau_ram.sv
module mau_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/mau_div.sv
module mau_div #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [63:0] quot
);

	localparam int unsigned NW = 32 + FRAC_BITS;
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [NW-1:0] q_q;
	logic [32:0]   r_q;
	logic [31:0]   d_q;
	logic          neg_q;
	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [33:0]   trial;
	logic [32:0]   rsh;
	logic signed [NW:0] qs;

	assign rsh = {r_q[31:0], n_q[NW-1]};
	assign trial = {1'b0, rsh} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= {(num[31] ? 32'(-num) : 32'(num)), {FRAC_BITS{1'b0}}};
			d_q <= den[31] ? 32'(-den) : 32'(den);
			neg_q <= num[31] ^ den[31];
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			if (!trial[33]) begin
				r_q <= trial[32:0];
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= rsh;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign qs = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
	assign quot = 64'(qs);

endmodule
